@@ rtl/sscomp_pkg.sv @@
// Package for the sparse-set component table: widths, operation and event codes.
// Used by every module of the block; depends on nothing.
`default_nettype none
package sscomp_pkg;
    localparam int NUM_SETS_D     = 4;
    localparam int ENTITY_SLOTS_D = 256;
    localparam int VALUE_WIDTH_D  = 32;

    localparam int OP_W   = 3;
    localparam int ENT_W  = 8;
    localparam int COMP_W = 2;
    localparam int VAL_W  = 32;
    localparam int EV_W   = 2;
    localparam int SLOT_W = 8;
    localparam int CNT_W  = 9;
    localparam int VER_W  = 32;

    localparam logic [OP_W-1:0] OP_INSERT  = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE  = 3'd1;
    localparam logic [OP_W-1:0] OP_QUERY   = 3'd2;
    localparam logic [OP_W-1:0] OP_TOUCH   = 3'd3;
    localparam logic [OP_W-1:0] OP_DESTROY = 3'd4;

    localparam logic [EV_W-1:0] EV_NONE     = 2'd0;
    localparam logic [EV_W-1:0] EV_INSERTED = 2'd1;
    localparam logic [EV_W-1:0] EV_UPDATED  = 2'd2;
    localparam logic [EV_W-1:0] EV_REMOVED  = 2'd3;

    // classified command handed from front to back
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ENT_W-1:0]  entity;
        logic [COMP_W-1:0] comp;
        logic [VAL_W-1:0]  value;
        logic              ent_ok;
        logic              comp_ok;
    } t_cmd;
endpackage
`default_nettype wire

@@ rtl/sscomp_front.sv @@
// Front end: accepts input words, classifies them and queues them for the back end.
// Depends on sscomp_pkg.
`default_nettype none
module sscomp_front #(
    parameter int NUM_SETS     = sscomp_pkg::NUM_SETS_D,
    parameter int ENTITY_SLOTS = sscomp_pkg::ENTITY_SLOTS_D,
    parameter int DEPTH        = 2
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [sscomp_pkg::OP_W-1:0]   i_operation,
    input  wire logic [sscomp_pkg::ENT_W-1:0]  i_entity,
    input  wire logic [sscomp_pkg::COMP_W-1:0] i_component,
    input  wire logic [sscomp_pkg::VAL_W-1:0]  i_value,
    output logic                              o_cmd_valid,
    input  wire logic                         i_cmd_take,
    output sscomp_pkg::t_cmd                  o_cmd
);
    import sscomp_pkg::*;
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_cmd           r_q [DEPTH];
    logic [PW-1:0]  r_wp, r_rp;
    logic [PW:0]    r_cnt;
    t_cmd           w_in;
    logic           w_push, w_pop;

    always_comb begin
        w_in.op      = i_operation;
        w_in.entity  = i_entity;
        w_in.comp    = i_component;
        w_in.value   = i_value;
        w_in.ent_ok  = 32'(i_entity) < ENTITY_SLOTS;
        w_in.comp_ok = 32'(i_component) < NUM_SETS;
    end

    assign o_stall     = (r_cnt == (PW+1)'(DEPTH));
    assign w_push      = i_valid && !o_stall;
    assign o_cmd_valid = (r_cnt != '0);
    assign w_pop       = o_cmd_valid && i_cmd_take;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= (32'(r_wp) == DEPTH-1) ? '0 : r_wp + 1'b1;
            if (w_pop)  r_rp <= (32'(r_rp) == DEPTH-1) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (PW+1)'(w_push) - (PW+1)'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_in;
    end
endmodule
`default_nettype wire

@@ rtl/sscomp_back.sv @@
// Back end: sequencer over the sparse map and dense memories, emits result words.
// Depends on sscomp_pkg.
`default_nettype none
module sscomp_back #(
    parameter int NUM_SETS     = sscomp_pkg::NUM_SETS_D,
    parameter int ENTITY_SLOTS = sscomp_pkg::ENTITY_SLOTS_D,
    parameter int VALUE_WIDTH  = sscomp_pkg::VALUE_WIDTH_D
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cmd_valid,
    output logic                               o_cmd_take,
    input  sscomp_pkg::t_cmd                   i_cmd,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [sscomp_pkg::EV_W-1:0]        o_event_res,
    output logic [sscomp_pkg::COMP_W-1:0]      o_set_id,
    output logic                               o_present,
    output logic [sscomp_pkg::VAL_W-1:0]       o_stored_value,
    output logic [sscomp_pkg::SLOT_W-1:0]      o_slot,
    output logic [sscomp_pkg::CNT_W-1:0]       o_set_size,
    output logic [sscomp_pkg::VER_W-1:0]       o_set_version,
    output logic                               o_last_result
);
    import sscomp_pkg::*;
    localparam int SW   = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int EW   = (ENTITY_SLOTS > 1) ? $clog2(ENTITY_SLOTS) : 1;
    localparam int DW   = EW;                     // dense slot index
    localparam int CW   = EW + 1;                 // count holds ENTITY_SLOTS
    localparam int VW   = VALUE_WIDTH;
    localparam int MW   = SW + EW;
    localparam int MD   = NUM_SETS * ENTITY_SLOTS;

    localparam logic [3:0] S_CLR      = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_MAP      = 4'd2;
    localparam logic [3:0] S_DENSE    = 4'd3;
    localparam logic [3:0] S_ACT      = 4'd4;
    localparam logic [3:0] S_MOVE     = 4'd5;
    localparam logic [3:0] S_OUT      = 4'd6;
    localparam logic [3:0] S_NEXT     = 4'd7;
    localparam logic [3:0] S_SCAN     = 4'd8;
    localparam logic [3:0] S_SCAN_ACC = 4'd9;

    // memories
    logic [DW:0]    m_map [MD];   // {valid, slot}
    logic [EW-1:0]  m_ent [MD];
    logic [VW-1:0]  m_val [MD];

    logic [CW-1:0]  r_cnt [NUM_SETS];
    logic [VER_W-1:0] r_ver [NUM_SETS];

    logic [3:0]     r_st;
    t_cmd           r_cmd;
    logic [SW-1:0]  r_set;
    logic           r_any;
    logic [MW-1:0]  r_clr;
    logic [NUM_SETS-1:0] r_mask;   // sets holding the entity being destroyed

    logic [DW:0]    r_map_q;
    logic [EW-1:0]  r_ent_q;
    logic [VW-1:0]  r_val_q;
    logic [VW-1:0]  r_last_v;

    // memory port controls
    logic           w_map_we;
    logic [MW-1:0]  w_map_wa, w_map_ra;
    logic [DW:0]    w_map_wd;
    logic           w_d_we;
    logic [MW-1:0]  w_d_wa, w_d_ra, w_d_ra2;
    logic [EW-1:0]  w_d_we_ent;
    logic [VW-1:0]  w_d_we_val;

    logic           r_ov;
    logic [EV_W-1:0] r_ev;
    logic [COMP_W-1:0] r_sid;
    logic           r_pres, r_lastr;
    logic [VAL_W-1:0] r_sv;
    logic [SLOT_W-1:0] r_slot;
    logic [CNT_W-1:0]  r_lc;
    logic [VER_W-1:0]  r_vr;

    logic [SW-1:0]  w_cs;
    logic [EW-1:0]  w_ce;
    logic           w_pres;
    logic [DW-1:0]  w_d;
    logic [CW-1:0]  w_c;
    logic [DW-1:0]  w_lastslot;
    logic           w_destroy;
    logic           w_last_set;
    logic           w_last_hit;

    assign w_destroy  = (r_cmd.op == OP_DESTROY);
    assign w_cs       = w_destroy ? r_set : r_cmd.comp[SW-1:0];
    assign w_ce       = r_cmd.entity[EW-1:0];
    assign w_pres     = r_cmd.ent_ok && r_map_q[DW];
    assign w_d        = r_map_q[DW-1:0];
    assign w_c        = r_cnt[w_cs];
    assign w_lastslot = DW'(w_c - 1'b1);
    assign w_last_set = (32'(r_set) == NUM_SETS-1);
    // no higher set holds the entity: this removal is the final word of the destroy
    assign w_last_hit = (((r_mask >> r_set) >> 1) == '0);
    assign o_cmd_take = (r_st == S_IDLE) && i_cmd_valid;

    assign o_valid        = r_ov;
    assign o_event_res    = r_ev;
    assign o_set_id       = r_sid;
    assign o_present      = r_pres;
    assign o_stored_value = r_sv;
    assign o_slot         = r_slot;
    assign o_set_size     = r_lc;
    assign o_set_version  = r_vr;
    assign o_last_result  = r_lastr;

    always_comb begin
        w_map_ra = {w_cs, w_ce};
        w_d_ra   = {w_cs, w_d};
        w_d_ra2  = {w_cs, w_lastslot};
        w_map_we = 1'b0;
        w_map_wa = {w_cs, w_ce};
        w_map_wd = '0;
        w_d_we   = 1'b0;
        w_d_wa   = {w_cs, w_d};
        w_d_we_ent = r_ent_q;
        w_d_we_val = r_last_v;
        if (r_st == S_CLR) begin
            w_map_we = 1'b1;
            w_map_wa = r_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_map_we) m_map[w_map_wa] <= w_map_wd;
        if (r_st == S_MAP || r_st == S_SCAN) r_map_q <= m_map[w_map_ra];
        if (r_st == S_DENSE) begin
            r_val_q  <= m_val[w_d_ra];
            r_ent_q  <= m_ent[w_d_ra2];
            r_last_v <= m_val[w_d_ra2];
        end
        if (w_d_we) begin
            m_ent[w_d_wa] <= w_d_we_ent;
            m_val[w_d_wa] <= w_d_we_val;
        end
        if (r_st == S_ACT && r_cmd.comp_ok && !w_destroy
            && r_cmd.op == OP_INSERT && r_cmd.ent_ok) begin
            if (w_pres) m_val[{w_cs, w_d}] <= r_cmd.value[VW-1:0];
            else begin
                m_val[{w_cs, DW'(w_c)}] <= r_cmd.value[VW-1:0];
                m_ent[{w_cs, DW'(w_c)}] <= w_ce;
                m_map[{w_cs, w_ce}]     <= {1'b1, DW'(w_c)};
            end
        end
        if (r_st == S_ACT && w_pres
            && (w_destroy || (r_cmd.comp_ok && r_cmd.op == OP_REMOVE))) begin
            m_map[{w_cs, w_ce}] <= '0;
            if (w_d != w_lastslot) begin
                m_ent[{w_cs, w_d}] <= r_ent_q;
                m_val[{w_cs, w_d}] <= r_last_v;
            end
        end
        if (r_st == S_MOVE && w_d != DW'(r_lc) && 32'(r_ent_q) < ENTITY_SLOTS)
            m_map[{w_cs, r_ent_q}] <= {1'b1, w_d};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= S_CLR;
            r_clr <= '0;
            r_ov  <= 1'b0;
            r_set <= '0;
            r_any <= 1'b0;
            for (int i = 0; i < NUM_SETS; i++) begin
                r_cnt[i] <= '0;
                r_ver[i] <= '0;
            end
        end else begin
            if (r_ov && !i_stall) r_ov <= 1'b0;
            case (r_st)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (32'(r_clr) == MD-1) r_st <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd  <= i_cmd;
                        r_set  <= '0;
                        r_any  <= 1'b0;
                        r_mask <= '0;
                        r_st   <= (i_cmd.op == OP_DESTROY) ? S_SCAN : S_MAP;
                    end
                end
                // destroy: find every set holding the entity before removing any
                S_SCAN: r_st <= S_SCAN_ACC;
                S_SCAN_ACC: begin
                    r_mask[r_set] <= w_pres;
                    if (w_last_set) begin
                        r_set <= '0;
                        r_st  <= S_MAP;
                    end else begin
                        r_set <= r_set + 1'b1;
                        r_st  <= S_SCAN;
                    end
                end
                S_MAP:   r_st <= S_DENSE;
                S_DENSE: r_st <= S_ACT;
                S_ACT: begin
                    if (!r_ov || !i_stall) begin
                        r_ov    <= 1'b1;
                        r_sid   <= COMP_W'(w_cs);
                        r_pres  <= w_pres;
                        r_lastr <= 1'b1;
                        r_ev    <= EV_NONE;
                        r_sv    <= '0;
                        r_slot  <= '0;
                        r_lc    <= CNT_W'(w_c);
                        r_vr    <= r_ver[w_cs];
                        r_st    <= S_IDLE;
                        if (w_destroy) begin
                            if (w_pres) begin
                                r_ev   <= EV_REMOVED;
                                r_sv   <= VAL_W'(r_val_q);
                                r_slot <= SLOT_W'(w_d);
                                r_lc   <= CNT_W'(w_c - 1'b1);
                                r_vr   <= r_ver[w_cs] + 1'b1;
                                r_lastr <= w_last_hit;
                                r_cnt[w_cs] <= w_c - 1'b1;
                                r_ver[w_cs] <= r_ver[w_cs] + 1'b1;
                                r_any  <= 1'b1;
                                r_st   <= S_MOVE;
                            end else if (!w_last_set) begin
                                r_ov <= 1'b0;
                                r_st <= S_NEXT;
                            end else if (r_any) begin
                                // final removal already carried last
                                r_ov <= 1'b0;
                                r_st <= S_IDLE;
                            end else begin
                                r_sid  <= '0;
                                r_lc   <= '0;
                                r_vr   <= '0;
                            end
                        end else if (!r_cmd.comp_ok) begin
                            r_sid  <= r_cmd.comp;
                            r_pres <= 1'b0;
                            r_lc   <= '0;
                            r_vr   <= '0;
                        end else if (r_cmd.op == OP_INSERT) begin
                            if (r_cmd.ent_ok) begin
                                r_ev   <= w_pres ? EV_UPDATED : EV_INSERTED;
                                r_sv   <= VAL_W'(r_cmd.value[VW-1:0]);
                                r_slot <= w_pres ? SLOT_W'(w_d) : SLOT_W'(w_c);
                                r_lc   <= w_pres ? CNT_W'(w_c) : CNT_W'(w_c + 1'b1);
                                r_vr   <= r_ver[w_cs] + 1'b1;
                                r_ver[w_cs] <= r_ver[w_cs] + 1'b1;
                                if (!w_pres) r_cnt[w_cs] <= w_c + 1'b1;
                            end
                        end else if (w_pres) begin
                            r_sv   <= VAL_W'(r_val_q);
                            r_slot <= SLOT_W'(w_d);
                            if (r_cmd.op == OP_REMOVE) begin
                                r_ev <= EV_REMOVED;
                                r_lc <= CNT_W'(w_c - 1'b1);
                                r_vr <= r_ver[w_cs] + 1'b1;
                                r_cnt[w_cs] <= w_c - 1'b1;
                                r_ver[w_cs] <= r_ver[w_cs] + 1'b1;
                                r_st <= S_MOVE;
                            end else if (r_cmd.op == OP_TOUCH) begin
                                r_ev <= EV_UPDATED;
                                r_vr <= r_ver[w_cs] + 1'b1;
                                r_ver[w_cs] <= r_ver[w_cs] + 1'b1;
                            end
                        end
                    end
                end
                S_MOVE: begin
                    if (w_destroy && !w_last_set) r_st <= S_NEXT;
                    else r_st <= S_IDLE;
                end
                S_NEXT: begin
                    r_set <= r_set + 1'b1;
                    r_st  <= S_MAP;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ rtl/sparse_set_component_table_top.sv @@
// Sparse-set component table: front queue plus back-end sequencer.
// The back end takes one command at a time: a map read, a dense read, then the update and
// result word, plus a move step on remove; destroy first scans every set, then repeats
// these steps per set. The result step waits while a stalled result word is still held.
// Reset: synchronous; a clearing pass over all NUM_SETS*ENTITY_SLOTS entries wipes the sparse
// map before the first item is taken from the queue.
// Depends on sscomp_pkg, sscomp_front, sscomp_back.
`default_nettype none
module sparse_set_component_table_top #(
    parameter int NUM_SETS     = sscomp_pkg::NUM_SETS_D,
    parameter int ENTITY_SLOTS = sscomp_pkg::ENTITY_SLOTS_D,
    parameter int VALUE_WIDTH  = sscomp_pkg::VALUE_WIDTH_D
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [sscomp_pkg::OP_W-1:0]   i_operation,
    input  wire logic [sscomp_pkg::ENT_W-1:0]  i_entity,
    input  wire logic [sscomp_pkg::COMP_W-1:0] i_component,
    input  wire logic [sscomp_pkg::VAL_W-1:0]  i_value,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [sscomp_pkg::EV_W-1:0]        o_event_res,
    output logic [sscomp_pkg::COMP_W-1:0]      o_set_id,
    output logic                               o_present,
    output logic [sscomp_pkg::VAL_W-1:0]       o_stored_value,
    output logic [sscomp_pkg::SLOT_W-1:0]      o_slot,
    output logic [sscomp_pkg::CNT_W-1:0]       o_set_size,
    output logic [sscomp_pkg::VER_W-1:0]       o_set_version,
    output logic                               o_last_result
);
    import sscomp_pkg::*;
    t_cmd w_cmd;
    logic w_cmd_valid, w_cmd_take;

    sscomp_front #(.NUM_SETS(NUM_SETS), .ENTITY_SLOTS(ENTITY_SLOTS)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_operation, .i_entity, .i_component, .i_value,
        .o_cmd_valid(w_cmd_valid), .i_cmd_take(w_cmd_take), .o_cmd(w_cmd)
    );

    sscomp_back #(.NUM_SETS(NUM_SETS), .ENTITY_SLOTS(ENTITY_SLOTS),
                  .VALUE_WIDTH(VALUE_WIDTH)) u_back (
        .i_clk, .i_rst_n,
        .i_cmd_valid(w_cmd_valid), .o_cmd_take(w_cmd_take), .i_cmd(w_cmd),
        .o_valid, .i_stall, .o_event_res, .o_set_id, .o_present, .o_stored_value,
        .o_slot, .o_set_size, .o_set_version, .o_last_result
    );
endmodule
`default_nettype wire

@@ rtl/sscomp_checker.sv @@
// Port-level checker for the component table, bound to the top level.
// Depends on sscomp_pkg.
`default_nettype none
module sscomp_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic [1:0] o_event_res,
    input wire logic       o_present,
    input wire logic [31:0] o_stored_value
);
    import sscomp_pkg::*;
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_stored_value))
        else $error("result word dropped while stalled");
    a_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_event_res == EV_REMOVED |-> o_present)
        else $error("removal without presence");
    a_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_event_res == EV_UPDATED |-> o_present)
        else $error("update without presence");
    a_ins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_event_res == EV_INSERTED |-> !o_present)
        else $error("insert of a present entity");
endmodule

bind sparse_set_component_table_top sscomp_checker u_chk (
    .i_clk, .i_rst_n, .o_valid, .i_stall, .o_event_res, .o_present, .o_stored_value
);
`default_nettype wire
